FILE: hw/rtl/pidaw_pkg.sv
// Shared types, constants and helper functions for the PID controller core.
// Used by every module of the block; depends on nothing else.

package pidaw_pkg;

   localparam int DataWidth   = 32;
   localparam int PeriodWidth = 16;
   localparam int FracBits    = 16;
   localparam int AddrWidth   = 5;

   // Error and measurement change are exact differences, one bit wider than the data.
   localparam int DiffWidth   = DataWidth + 1;
   // Gain times difference, exact.
   localparam int ProdWidth   = DataWidth + DiffWidth;
   // Product after the Q32.32 to Q16.16 shift.
   localparam int TermWidth   = ProdWidth - FracBits;
   // Wide enough for P + I - D without any intermediate overflow.
   localparam int SumWidth    = TermWidth + 3;

   localparam logic signed [DataWidth-1:0] PGainReset  = 32'sd65536;
   localparam logic signed [DataWidth-1:0] IGainReset  = 32'sd0;
   localparam logic signed [DataWidth-1:0] DGainReset  = 32'sd0;
   localparam logic signed [DataWidth-1:0] LowerReset  = 32'sd0;
   localparam logic signed [DataWidth-1:0] UpperReset  = 32'sd6553600;
   localparam logic [PeriodWidth-1:0]      PeriodReset = 16'd100;

   typedef enum logic [2:0] {
      REG_PGAIN  = 3'd0,
      REG_IGAIN  = 3'd1,
      REG_DGAIN  = 3'd2,
      REG_LOWER  = 3'd3,
      REG_UPPER  = 3'd4,
      REG_PERIOD = 3'd5
   } pidaw_reg_index_type;

   typedef struct packed {
      logic signed [DataWidth-1:0] target;
      logic signed [DataWidth-1:0] measurement;
      logic [DataWidth-1:0]        now_ms;
   } pidaw_req_type;

   typedef struct packed {
      logic signed [DataWidth-1:0] drive;
      logic                        updated;
   } pidaw_rsp_type;

   typedef struct packed {
      logic signed [DataWidth-1:0] proportional_gain;
      logic signed [DataWidth-1:0] integral_gain;
      logic signed [DataWidth-1:0] derivative_gain;
      logic signed [DataWidth-1:0] lower_limit;
      logic signed [DataWidth-1:0] upper_limit;
      logic [PeriodWidth-1:0]      sample_period;
   } pidaw_cfg_type;

   // Clamp a wide sum to the limits. The lower limit is tested first, so with
   // inverted limits everything not below the lower limit lands on the upper one.
   function automatic logic signed [DataWidth-1:0] clamp_limits(
      input logic signed [SumWidth-1:0]  value,
      input logic signed [DataWidth-1:0] lower,
      input logic signed [DataWidth-1:0] upper
   );
      logic signed [SumWidth-1:0] lower_ext;
      logic signed [SumWidth-1:0] upper_ext;
      logic signed [DataWidth-1:0] result;
      lower_ext = {{(SumWidth-DataWidth){lower[DataWidth-1]}}, lower};
      upper_ext = {{(SumWidth-DataWidth){upper[DataWidth-1]}}, upper};
      if (value < lower_ext) begin
         result = lower;
      end else if (value > upper_ext) begin
         result = upper;
      end else begin
         result = value[DataWidth-1:0];
      end
      return result;
   endfunction

   // Gain times difference, reduced to Q16.16 with rounding toward minus infinity.
   function automatic logic signed [TermWidth-1:0] gain_term(
      input logic signed [DataWidth-1:0] gain,
      input logic signed [DiffWidth-1:0] diff
   );
      logic signed [ProdWidth-1:0] prod;
      prod = {{DiffWidth{gain[DataWidth-1]}}, gain} *
             {{DataWidth{diff[DiffWidth-1]}}, diff};
      return prod[ProdWidth-1:FracBits];
   endfunction

endpackage

FILE: hw/rtl/pidaw_csr.sv
// Configuration register file of the PID controller core, APB-style access.
// Depends on pidaw_pkg for the register map and the configuration struct.

module pidaw_csr import pidaw_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [AddrWidth-1:0] csr_paddr,
   input  logic [DataWidth-1:0] csr_pwdata,
   output logic [DataWidth-1:0] csr_prdata,
   output logic                 csr_pready,
   output pidaw_cfg_type        cfg
);

   pidaw_cfg_type       cfg_ff;
   pidaw_cfg_type       cfg_in;
   pidaw_reg_index_type reg_index;
   logic                write_strobe;

   assign csr_pready   = 1'b1;
   assign reg_index    = pidaw_reg_index_type'(csr_paddr[AddrWidth-1:2]);
   assign write_strobe = csr_psel & csr_penable & csr_pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_strobe) begin
         unique case (reg_index)
            REG_PGAIN:  cfg_in.proportional_gain = csr_pwdata;
            REG_IGAIN:  cfg_in.integral_gain     = csr_pwdata;
            REG_DGAIN:  cfg_in.derivative_gain   = csr_pwdata;
            REG_LOWER:  cfg_in.lower_limit       = csr_pwdata;
            REG_UPPER:  cfg_in.upper_limit       = csr_pwdata;
            REG_PERIOD: cfg_in.sample_period     = csr_pwdata[PeriodWidth-1:0];
            default:    cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         REG_PGAIN:  csr_prdata = cfg_ff.proportional_gain;
         REG_IGAIN:  csr_prdata = cfg_ff.integral_gain;
         REG_DGAIN:  csr_prdata = cfg_ff.derivative_gain;
         REG_LOWER:  csr_prdata = cfg_ff.lower_limit;
         REG_UPPER:  csr_prdata = cfg_ff.upper_limit;
         REG_PERIOD: csr_prdata = {{(DataWidth-PeriodWidth){1'b0}}, cfg_ff.sample_period};
         default:    csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.proportional_gain <= PGainReset;
         cfg_ff.integral_gain     <= IGainReset;
         cfg_ff.derivative_gain   <= DGainReset;
         cfg_ff.lower_limit       <= LowerReset;
         cfg_ff.upper_limit       <= UpperReset;
         cfg_ff.sample_period     <= PeriodReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: hw/rtl/pidaw_datapath.sv
// Control law and controller state: error, gain products, integrator, clamp.
// Depends on pidaw_pkg for the item structs and the arithmetic helpers.

module pidaw_datapath import pidaw_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          advance,
   input  pidaw_req_type item,
   input  pidaw_cfg_type cfg,
   output pidaw_rsp_type result
);

   logic signed [DataWidth-1:0] integrator_ff, integrator_in;
   logic signed [DataWidth-1:0] prev_meas_ff, prev_meas_in;
   logic [DataWidth-1:0]        last_time_ff, last_time_in;
   logic signed [DataWidth-1:0] held_drive_ff, held_drive_in;

   logic [DataWidth-1:0]        elapsed;
   logic                        due;
   logic signed [DiffWidth-1:0] error;
   logic signed [DiffWidth-1:0] change;
   logic signed [TermWidth-1:0] p_term;
   logic signed [TermWidth-1:0] i_term;
   logic signed [TermWidth-1:0] d_term;
   logic signed [SumWidth-1:0]  integ_sum;
   logic signed [SumWidth-1:0]  drive_sum;
   logic signed [DataWidth-1:0] integ_new;
   logic signed [DataWidth-1:0] drive_new;

   // Wrapping time difference since the last update.
   assign elapsed = item.now_ms - last_time_ff;
   assign due     = elapsed >= {{(DataWidth-PeriodWidth){1'b0}}, cfg.sample_period};

   assign error  = {item.target[DataWidth-1], item.target}
                 - {item.measurement[DataWidth-1], item.measurement};
   assign change = {item.measurement[DataWidth-1], item.measurement}
                 - {prev_meas_ff[DataWidth-1], prev_meas_ff};

   assign p_term = gain_term(cfg.proportional_gain, error);
   assign i_term = gain_term(cfg.integral_gain, error);
   assign d_term = gain_term(cfg.derivative_gain, change);

   assign integ_sum = {{(SumWidth-TermWidth){i_term[TermWidth-1]}}, i_term}
                    + {{(SumWidth-DataWidth){integrator_ff[DataWidth-1]}}, integrator_ff};
   assign integ_new = clamp_limits(integ_sum, cfg.lower_limit, cfg.upper_limit);

   assign drive_sum = {{(SumWidth-TermWidth){p_term[TermWidth-1]}}, p_term}
                    + {{(SumWidth-DataWidth){integ_new[DataWidth-1]}}, integ_new}
                    - {{(SumWidth-TermWidth){d_term[TermWidth-1]}}, d_term};
   assign drive_new = clamp_limits(drive_sum, cfg.lower_limit, cfg.upper_limit);

   always_comb begin
      integrator_in = integrator_ff;
      prev_meas_in  = prev_meas_ff;
      last_time_in  = last_time_ff;
      held_drive_in = held_drive_ff;
      if (advance && due) begin
         integrator_in = integ_new;
         prev_meas_in  = item.measurement;
         last_time_in  = item.now_ms;
         held_drive_in = drive_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         integrator_ff <= '0;
         prev_meas_ff  <= '0;
         last_time_ff  <= '0;
         held_drive_ff <= '0;
      end else begin
         integrator_ff <= integrator_in;
         prev_meas_ff  <= prev_meas_in;
         last_time_ff  <= last_time_in;
         held_drive_ff <= held_drive_in;
      end
   end

   assign result.drive   = due ? drive_new : held_drive_ff;
   assign result.updated = due;

endmodule

FILE: hw/rtl/pid_controller_antiwindup_core.sv
// Top level of the PID controller core: input register, result register,
// configuration registers and control datapath. Depends on pidaw_pkg,
// pidaw_csr and pidaw_datapath.

// The core is a discrete PID controller in signed Q16.16 with derivative on
// measurement and an integrator clamped to the output limits. Every request
// beat carries a target, a measurement and a millisecond time stamp, and
// produces exactly one response beat. When at least sample_period
// milliseconds have passed since the last update (wrapping 32-bit
// difference), the response carries a freshly computed drive and updated is
// set; otherwise it carries the held drive with updated clear. A beat is
// captured in an input register, and in the cycle it moves on to the result
// register the whole control law runs in one pass: three gain multipliers,
// the integrator sum and clamp, then the P + I - D sum and clamp. The
// controller state is written in that same cycle, so the next beat can follow
// immediately: throughput is one beat per clock while responses are not
// stalled, and a response is offered once its beat has passed the input
// register and then the result register. The result register decouples the
// two channels, so the core keeps taking requests while a response waits, and
// stalls only when both registers are full and the response is stalled.
// The gain, limit and period registers sit on an APB-style port at byte
// addresses 0, 4, 8, 12, 16 and 20; they should be written only while no
// beat is in flight.

module pid_controller_antiwindup_core import pidaw_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,

   input  logic                 req_valid,
   output logic                 req_stall,
   input  pidaw_req_type        req_data,

   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output pidaw_rsp_type        rsp_data,

   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [AddrWidth-1:0] csr_paddr,
   input  logic [DataWidth-1:0] csr_pwdata,
   output logic [DataWidth-1:0] csr_prdata,
   output logic                 csr_pready
);

   pidaw_cfg_type cfg;

   logic          in_valid_ff, in_valid_in;
   pidaw_req_type in_data_ff, in_data_in;
   logic          out_valid_ff, out_valid_in;
   pidaw_rsp_type out_data_ff, out_data_in;

   pidaw_rsp_type result;
   logic          advance;
   logic          req_take;

   // The input beat moves on whenever the result register is empty or its
   // beat is being taken in this same cycle.
   assign advance   = in_valid_ff & (~out_valid_ff | ~rsp_stall);
   assign req_stall = in_valid_ff & ~advance;
   assign req_take  = req_valid & ~req_stall;

   pidaw_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   pidaw_datapath u_datapath (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (in_data_ff),
      .cfg     (cfg),
      .result  (result)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      in_data_in  = in_data_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
         in_data_in  = req_data;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      if (advance) begin
         out_valid_in = 1'b1;
         out_data_in  = result;
      end else if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers carry no reset; their valid flags guard them.
   always_ff @(posedge clock) begin
      in_data_ff  <= in_data_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

FILE: verif/tb_pid_controller_antiwindup_core.sv
// Testbench for pid_controller_antiwindup_core: directed and random control samples,
// register setup over the APB-style port, and a scoreboard with its own drive predictor.
// Depends on pidaw_pkg and the core RTL only.
`timescale 1ns / 100ps

module tb_pid_controller_antiwindup_core import pidaw_pkg::*; ();

   // Predicts the drive for every accepted request beat and checks the
   // response beats against those predictions in order.
   class drive_scoreboard;
      logic signed [DataWidth-1:0] kp, ki, kd, lo_lim, hi_lim;
      logic [PeriodWidth-1:0]      period;
      logic signed [DataWidth-1:0] integ, prev_meas, held;
      logic [DataWidth-1:0]        last_time;
      pidaw_rsp_type               expected_drives[$];
      int                          failures;

      function new();
         kp = PGainReset;
         ki = IGainReset;
         kd = DGainReset;
         lo_lim = LowerReset;
         hi_lim = UpperReset;
         period = PeriodReset;
         integ = '0;
         prev_meas = '0;
         held = '0;
         last_time = '0;
         failures = 0;
      endfunction

      function void write_register(logic [2:0] index, logic [31:0] value);
         case (index)
            REG_PGAIN:  kp = value;
            REG_IGAIN:  ki = value;
            REG_DGAIN:  kd = value;
            REG_LOWER:  lo_lim = value;
            REG_UPPER:  hi_lim = value;
            REG_PERIOD: period = value[PeriodWidth-1:0];
            default: ;
         endcase
      endfunction

      // Lower limit is tested first, which also settles inverted limits.
      function logic signed [DataWidth-1:0] bound_drive(logic signed [SumWidth-1:0] v);
         if (v < lo_lim) return lo_lim;
         if (v > hi_lim) return hi_lim;
         return v[DataWidth-1:0];
      endfunction

      function void note_request(pidaw_req_type req);
         logic [DataWidth-1:0]        elapsed;
         logic signed [DiffWidth-1:0] err, change;
         logic signed [ProdWidth-1:0] p_prod, i_prod, d_prod;
         logic signed [SumWidth-1:0]  acc;
         pidaw_rsp_type               rsp;
         elapsed = req.now_ms - last_time;
         rsp.updated = 1'b0;
         if (elapsed >= {{(DataWidth-PeriodWidth){1'b0}}, period}) begin
            err = $signed(req.target) - $signed(req.measurement);
            change = $signed(req.measurement) - prev_meas;
            p_prod = kp * err;
            i_prod = ki * err;
            d_prod = kd * change;
            // Arithmetic shifts floor the Q32.32 products to Q16.16.
            acc = integ + (i_prod >>> FracBits);
            integ = bound_drive(acc);
            acc = (p_prod >>> FracBits) + integ - (d_prod >>> FracBits);
            held = bound_drive(acc);
            prev_meas = req.measurement;
            last_time = req.now_ms;
            rsp.updated = 1'b1;
         end
         rsp.drive = held;
         expected_drives.push_back(rsp);
      endfunction

      function void check_response(pidaw_rsp_type got);
         pidaw_rsp_type want;
         if (expected_drives.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("unexpected response: drive %h updated %b", got.drive, got.updated);
         end else begin
            want = expected_drives.pop_front();
            if (got.drive !== want.drive || got.updated !== want.updated) begin
               failures++;
               if (failures <= 10)
                  $display("response mismatch: expected drive %h updated %b, got drive %h updated %b",
                           want.drive, want.updated, got.drive, got.updated);
            end
         end
      endfunction
   endclass

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   pidaw_req_type        req_data = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   pidaw_rsp_type        rsp_data;
   logic                 csr_psel = 1'b0;
   logic                 csr_penable = 1'b0;
   logic                 csr_pwrite = 1'b0;
   logic [AddrWidth-1:0] csr_paddr = '0;
   logic [DataWidth-1:0] csr_pwdata = '0;
   logic [DataWidth-1:0] csr_prdata;
   logic                 csr_pready;

   drive_scoreboard scoreboard = new();

   // Idle bursts are switched off for the final phase of the run.
   bit                   sender_idles = 1'b1;
   bit                   receiver_idles = 1'b1;
   logic [31:0]          stamp_ms = '0;

   pid_controller_antiwindup_core DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // A word biased toward the corners: the signed extremes, zero, minus one,
   // small signed values, and otherwise anything at all.
   function automatic logic [31:0] random_word();
      logic [31:0] w;
      w = $urandom();
      case ($urandom_range(0, 9))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'h0000_0000;
         3: return 32'hffff_ffff;
         4, 5: return {{10{w[21]}}, w[21:0]};
         default: return w;
      endcase
   endfunction

   // A gain that mostly stays within 2^(bits-17) in magnitude, so the
   // control law is exercised away from permanent saturation.
   function automatic logic [31:0] pick_gain(int bits);
      logic signed [31:0] s;
      if ($urandom_range(0, 3) == 0) return random_word();
      s = $urandom();
      s = s <<< (32 - bits);
      s = s >>> (32 - bits);
      return s;
   endfunction

   function automatic pidaw_req_type make_beat(logic [31:0] target, logic [31:0] meas,
                                               logic [31:0] now);
      pidaw_req_type b;
      b.target = target;
      b.measurement = meas;
      b.now_ms = now;
      return b;
   endfunction

   // One register write: setup cycle, then access cycle until pready. The
   // predictor takes the new value at the edge where the core does.
   task automatic csr_write(input logic [2:0] index, input logic [31:0] value);
      @(negedge clock);
      csr_psel = 1'b1;
      csr_pwrite = 1'b1;
      csr_penable = 1'b0;
      csr_paddr = {index, 2'b00};
      csr_pwdata = value;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      scoreboard.write_register(index, value);
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
   endtask

   // Offers one request beat, possibly after an idle burst with junk payload,
   // and holds it until the core takes it.
   task automatic send_beat(input pidaw_req_type beat);
      int gap;
      if (sender_idles && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 8);
         repeat (gap) begin
            @(negedge clock);
            req_valid = 1'b0;
            req_data = {$urandom(), $urandom(), $urandom()};
         end
      end
      @(negedge clock);
      req_valid = 1'b1;
      req_data = beat;
      do @(posedge clock); while (req_stall);
      scoreboard.note_request(beat);
   endtask

   // Stops sending and waits until every predicted response has arrived, then
   // lets the two-stage pipeline settle before registers may be touched.
   task automatic drain_results();
      @(negedge clock);
      req_valid = 1'b0;
      while (scoreboard.expected_drives.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic randomize_settings();
      logic [31:0] lo, hi, w;
      csr_write(REG_PGAIN, pick_gain(20));
      csr_write(REG_IGAIN, pick_gain(16));
      csr_write(REG_DGAIN, pick_gain(18));
      w = $urandom();
      case ($urandom_range(0, 3))
         0: begin
            lo = random_word();
            hi = random_word();
         end
         1: begin
            lo = 32'h8000_0000;
            hi = 32'h7fff_ffff;
         end
         default: begin
            lo = -{4'b0000, w[27:0]};
            w = $urandom();
            hi = {4'b0000, w[27:0]};
         end
      endcase
      csr_write(REG_LOWER, lo);
      csr_write(REG_UPPER, hi);
      case ($urandom_range(0, 5))
         0: w = 32'd0;
         1: w = 32'd65535;
         2: w = $urandom();
         default: w = $urandom_range(1, 200);
      endcase
      csr_write(REG_PERIOD, w);
      // Addresses past the last register must leave everything alone.
      if ($urandom_range(0, 3) == 0) csr_write(3'($urandom_range(6, 7)), $urandom());
   endtask

   // Mostly a plant that tracks a setpoint with small noise, sampled around
   // the sample period so updates and holds interleave; now and then a wild
   // sample or a time jump that wraps the millisecond counter.
   task automatic run_random_phase(input int count);
      pidaw_req_type beat;
      logic [31:0]   setpoint, noise, step, per;
      setpoint = random_word();
      for (int n = 0; n < count; n++) begin
         per = {16'h0000, scoreboard.period};
         if ($urandom_range(0, 19) == 0) setpoint = random_word();
         case ($urandom_range(0, 9))
            0: step = $urandom();
            1: step = per;
            2: step = per - 1;
            default: step = $urandom_range(0, 2 * per + 2);
         endcase
         stamp_ms = stamp_ms + step;
         if ($urandom_range(0, 4) == 0) begin
            beat.target = random_word();
            beat.measurement = random_word();
         end else begin
            noise = $urandom();
            beat.target = setpoint;
            beat.measurement = setpoint + {{12{noise[19]}}, noise[19:0]};
         end
         beat.now_ms = stamp_ms;
         send_beat(beat);
      end
   endtask

   // Response side: check every accepted beat at the rising edge, and change
   // the stall at the falling edge in random bursts.
   initial begin
      int hold;
      hold = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) scoreboard.check_response(rsp_data);
         @(negedge clock);
         if (hold == 0 && receiver_idles && $urandom_range(0, 5) == 0)
            hold = $urandom_range(1, 8);
         rsp_stall = (hold > 0);
         if (hold > 0) hold--;
      end
   end

   initial begin
      #2_000_000;
      $display("Verification failed");
      $finish;
   end

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Reset settings: early time stamps hold the zero drive, then a full
      // scale error pins the output to each limit in turn.
      send_beat(make_beat(32'h7fff_ffff, 32'h8000_0000, 32'd0));
      send_beat(make_beat(32'h0001_0000, 32'h0000_0000, 32'd99));
      send_beat(make_beat(32'h7fff_ffff, 32'h8000_0000, 32'd100));
      send_beat(make_beat(32'h0005_0000, 32'h0000_0000, 32'd150));
      send_beat(make_beat(32'h8000_0000, 32'h7fff_ffff, 32'd200));
      send_beat(make_beat(32'h0032_0000, 32'h0010_0000, 32'd300));
      drain_results();

      // Extreme gains with the widest limits and a zero period, so every
      // beat updates, even one with an unchanged time stamp.
      csr_write(REG_PGAIN, 32'h8000_0000);
      csr_write(REG_IGAIN, 32'h7fff_ffff);
      csr_write(REG_DGAIN, 32'h8000_0000);
      csr_write(REG_LOWER, 32'h8000_0000);
      csr_write(REG_UPPER, 32'h7fff_ffff);
      csr_write(REG_PERIOD, 32'd0);
      csr_write(3'd6, 32'h7fff_ffff);
      csr_write(3'd7, 32'h8000_0000);
      send_beat(make_beat(32'h7fff_ffff, 32'h8000_0000, 32'd300));
      send_beat(make_beat(32'h8000_0000, 32'h7fff_ffff, 32'd300));
      send_beat(make_beat(32'h0000_0000, 32'h0000_0000, 32'hffff_ffff));
      send_beat(make_beat(32'h7fff_ffff, 32'h7fff_ffff, 32'd0));
      send_beat(make_beat(32'h8000_0000, 32'h8000_0000, 32'd5));
      send_beat(make_beat(32'hffff_ffff, 32'h0000_0001, 32'd6));
      send_beat(make_beat(32'h0001_0000, 32'hffff_0000, 32'd7));
      drain_results();
      csr_write(REG_PGAIN, 32'h7fff_ffff);
      csr_write(REG_IGAIN, 32'h8000_0000);
      csr_write(REG_DGAIN, 32'h7fff_ffff);
      send_beat(make_beat(32'h7fff_ffff, 32'h8000_0000, 32'd8));
      send_beat(make_beat(32'h8000_0000, 32'h7fff_ffff, 32'd9));
      send_beat(make_beat(32'h0000_0000, 32'h0000_0000, 32'd10));
      drain_results();

      // Inverted limits with the longest period: anything not below the
      // lower limit lands on the upper one, and the elapsed time is taken
      // across the wrap of the millisecond counter.
      csr_write(REG_PGAIN, 32'h0001_0000);
      csr_write(REG_IGAIN, 32'h0000_0000);
      csr_write(REG_DGAIN, 32'h0000_0000);
      csr_write(REG_LOWER, 32'h03e8_0000);
      csr_write(REG_UPPER, 32'hfc18_0000);
      csr_write(REG_PERIOD, 32'd65535);
      send_beat(make_beat(32'h0000_0000, 32'h0000_0000, 32'hffff_ff00));
      send_beat(make_beat(32'h7fff_0000, 32'h0000_0000, 32'h0000_fefe));
      send_beat(make_beat(32'h7fff_0000, 32'h0000_0000, 32'h0000_feff));
      send_beat(make_beat(32'h8000_0000, 32'h0000_0000, 32'h0001_fefe));
      drain_results();
      stamp_ms = 32'h0001_fefe;

      // Random phases, each with fresh settings; the sender waits for every
      // response before the next round of register writes.
      for (int phase = 0; phase < 10; phase++) begin
         randomize_settings();
         if (phase == 9) begin
            sender_idles = 1'b0;
            receiver_idles = 1'b0;
         end
         run_random_phase(150);
         drain_results();
      end

      repeat (8) @(posedge clock);
      if (scoreboard.failures == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

FILE: sim.f
hw/rtl/pidaw_pkg.sv
hw/rtl/pidaw_csr.sv
hw/rtl/pidaw_datapath.sv
hw/rtl/pid_controller_antiwindup_core.sv
verif/tb_pid_controller_antiwindup_core.sv
